// ----- src/ftsm_pkg.sv -----
// ----------------------------------------------------------------------------
// ftsm_pkg: shared types and constants of the fan tachometer speed meter
// Edge windows, register map, result limits and divider state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsm_pkg;

  // Field widths fixed by the interface
  localparam int TSTAMP_IN_W = 32;
  localparam int SCALE_W     = 32;
  localparam int SPEED_W     = 16;
  localparam int HIST_W      = 4;
  localparam int WIN_W       = HIST_W + 1;

  // Qualified edge windows, oldest sample in the top bit
  localparam logic [WIN_W-1:0] WIN_RISE = 5'b00111;
  localparam logic [WIN_W-1:0] WIN_FALL = 5'b11000;

  localparam logic [SPEED_W-1:0] SPEED_MAX       = 16'hFFFF;
  localparam logic [SCALE_W-1:0] RPM_SCALE_RESET = 32'd1500000000;

  // Register port: word index taken from paddr[PADDR_W-1]
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_RPM_SCALE = 1'b0;

  // Divider sequencing: one quotient bit per step
  localparam int STEP_W = $clog2(SCALE_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SCALE_W - 1);

  // Queue between edge tracker and divider
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

`default_nettype wire

// ----- src/fan_tacho_speed_meter.sv -----
// ----------------------------------------------------------------------------
// fan_tacho_speed_meter: fan speed from tachometer samples
// Qualifies tachometer edges, averages the rise and fall periods and divides
// the programmed scale by that average to give a saturated speed.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  sample   | sample_valid / sample_stall | tach_level, timestamp
//  result   | result_valid / result_stall | speed_rpm, speed_valid
//  config   | APB write, pready tied high | rpm_scale at byte address 0
//
//  A sample is taken whenever the queue has room; the divider works on one
//  result at a time (a load, 32 restoring steps, a move into the output register).
//  The two-entry queue ahead of the divider and the output register let
//  the sample and result sides stall independently.
//  Synchronous reset clears history, edge times, periods and the queue and
//  loads rpm_scale with 1500000000. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_tacho_speed_meter #(
  parameter int TIMESTAMP_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Sample channel
  input  wire logic                           sample_valid,
  output logic                                sample_stall,
  input  wire logic                           tach_level,
  input  wire logic [ftsm_pkg::TSTAMP_IN_W-1:0] timestamp,
  // Result channel
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [ftsm_pkg::SPEED_W-1:0]        speed_rpm,
  output logic                                speed_valid,
  // Register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ftsm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ftsm_pkg::PDATA_W-1:0]   pwdata,
  output logic [ftsm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [ftsm_pkg::SCALE_W-1:0] rpm_scale;
  logic                         reg_sel;
  logic                         reg_write;

  logic                         q_push;
  logic [TIMESTAMP_WIDTH-1:0]   q_push_avg;
  logic                         q_full;
  logic                         q_pop;
  logic [TIMESTAMP_WIDTH-1:0]   q_pop_avg;
  logic                         q_not_empty;

  // Register port; low address bits select a byte lane and are ignored
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[ftsm_pkg::PADDR_W-1] == ftsm_pkg::REG_RPM_SCALE);
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? ftsm_pkg::PDATA_W'(rpm_scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_scale <= ftsm_pkg::RPM_SCALE_RESET;
    end else if (reg_write && reg_sel) begin
      rpm_scale <= pwdata[ftsm_pkg::SCALE_W-1:0];
    end
  end

  // Edge tracker
  ftsm_front #(
    .TS_W (TIMESTAMP_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .tach_level   (tach_level),
    .timestamp    (timestamp),
    .push         (q_push),
    .push_avg     (q_push_avg),
    .full         (q_full)
  );

  // Averaged period queue
  ftsm_queue #(
    .W (TIMESTAMP_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_avg),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_avg),
    .not_empty (q_not_empty)
  );

  // Divider and result register
  ftsm_divider #(
    .TS_W (TIMESTAMP_WIDTH)
  ) u_divider (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_avg        (q_pop_avg),
    .q_pop        (q_pop),
    .rpm_scale    (rpm_scale),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .speed_rpm    (speed_rpm),
    .speed_valid  (speed_valid)
  );

endmodule

`default_nettype wire

// ----- src/ftsm_front.sv -----
// ----------------------------------------------------------------------------
// ftsm_front: edge tracker
// Keeps the sample history, qualifies rising and falling edges, tracks both
// periods and pushes the averaged period into the queue per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsm_front #(
  parameter int TS_W = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_stall,
  input  wire logic                           tach_level,
  input  wire logic [ftsm_pkg::TSTAMP_IN_W-1:0] timestamp,
  output logic                                push,
  output logic [TS_W-1:0]                     push_avg,
  input  wire logic                           full
);

  logic [ftsm_pkg::HIST_W-1:0] history;
  logic [TS_W-1:0]             last_rise_time;
  logic [TS_W-1:0]             rise_period;
  logic [TS_W-1:0]             last_fall_time;
  logic [TS_W-1:0]             fall_period;

  logic [ftsm_pkg::WIN_W-1:0]  window;
  logic [TS_W-1:0]             ts;
  logic                        rise_hit;
  logic                        fall_hit;
  logic [TS_W-1:0]             rise_period_next;
  logic [TS_W-1:0]             fall_period_next;
  logic                        accept;

  // Transfer handshake: only the queue can hold us off
  assign sample_stall = full;
  assign accept       = sample_valid && !full;
  assign push         = accept;

  // Edge qualification
  assign ts       = TS_W'(timestamp);
  assign window   = {history, tach_level};
  assign rise_hit = (window == ftsm_pkg::WIN_RISE);
  assign fall_hit = (window == ftsm_pkg::WIN_FALL);

  assign rise_period_next = rise_hit ? (ts - last_rise_time) : rise_period;
  assign fall_period_next = fall_hit ? (ts - last_fall_time) : fall_period;

  // Floor of the half sum, without a carry out
  assign push_avg = (rise_period_next >> 1) + (fall_period_next >> 1)
                  + TS_W'(rise_period_next[0] & fall_period_next[0]);

  // Edge state
  always_ff @(posedge clk) begin
    if (rst) begin
      history        <= '0;
      last_rise_time <= '0;
      rise_period    <= '0;
      last_fall_time <= '0;
      fall_period    <= '0;
    end else if (accept) begin
      history     <= window[ftsm_pkg::HIST_W-1:0];
      rise_period <= rise_period_next;
      fall_period <= fall_period_next;
      if (rise_hit) begin
        last_rise_time <= ts;
      end
      if (fall_hit) begin
        last_fall_time <= ts;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/ftsm_queue.sv -----
// ----------------------------------------------------------------------------
// ftsm_queue: short FIFO between edge tracker and divider
// Holds averaged periods so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsm_queue #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              not_empty
);

  localparam int PTR_W = (ftsm_pkg::QUEUE_DEPTH > 1) ? $clog2(ftsm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ftsm_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ftsm_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ftsm_pkg::QUEUE_DEPTH - 1);

  logic [W-1:0]     entries [ftsm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/ftsm_divider.sv -----
// ----------------------------------------------------------------------------
// ftsm_divider: speed computation
// Restoring divider, one quotient bit per cycle, then saturation and the
// result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsm_divider #(
  parameter int TS_W = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire logic [TS_W-1:0]               q_avg,
  output logic                               q_pop,
  input  wire logic [ftsm_pkg::SCALE_W-1:0]  rpm_scale,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [ftsm_pkg::SPEED_W-1:0]       speed_rpm,
  output logic                               speed_valid
);

  ftsm_pkg::div_state_t state;
  ftsm_pkg::div_state_t state_next;

  logic [ftsm_pkg::SCALE_W-1:0] dvd;       // dividend in, quotient out
  logic [TS_W-1:0]              rem;
  logic [TS_W-1:0]              divisor;
  logic                         div_zero;
  logic [ftsm_pkg::STEP_W-1:0]  step;

  logic [TS_W:0]                rem_shift;
  logic [TS_W:0]                rem_sub;
  logic                         ge;
  logic [TS_W-1:0]              rem_next;
  logic                         out_free;
  logic                         load_out;
  logic                         start;
  logic [ftsm_pkg::SPEED_W-1:0] speed_next;

  // One restoring step
  assign rem_shift = {rem, dvd[ftsm_pkg::SCALE_W-1]};
  assign ge        = (rem_shift >= {1'b0, divisor});
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rem_next  = ge ? rem_sub[TS_W-1:0] : rem_shift[TS_W-1:0];

  // Saturated quotient, zero when there is no period
  always_comb begin
    if (div_zero) begin
      speed_next = '0;
    end else if (|dvd[ftsm_pkg::SCALE_W-1:ftsm_pkg::SPEED_W]) begin
      speed_next = ftsm_pkg::SPEED_MAX;
    end else begin
      speed_next = dvd[ftsm_pkg::SPEED_W-1:0];
    end
  end

  assign out_free = !result_valid || !result_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftsm_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    start      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ftsm_pkg::DIV_IDLE: begin
        if (q_valid) begin
          start      = 1'b1;
          state_next = ftsm_pkg::DIV_RUN;
        end
      end
      ftsm_pkg::DIV_RUN: begin
        if (step == ftsm_pkg::STEP_LAST) begin
          state_next = ftsm_pkg::DIV_DONE;
        end
      end
      ftsm_pkg::DIV_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ftsm_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_next = ftsm_pkg::DIV_IDLE;
      end
    endcase
  end

  assign q_pop = start;

  // Divider datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= rpm_scale;
      rem      <= '0;
      divisor  <= q_avg;
      div_zero <= (q_avg == '0);
      step     <= '0;
    end else if (state == ftsm_pkg::DIV_RUN) begin
      dvd  <= {dvd[ftsm_pkg::SCALE_W-2:0], ge};
      rem  <= rem_next;
      step <= step + 1'b1;
    end
  end

  // Result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      speed_rpm   <= speed_next;
      speed_valid <= !div_zero;
    end
  end

  // Last quotient bit always leads to the done state
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ftsm_pkg::DIV_RUN && step == ftsm_pkg::STEP_LAST)
      |=> (state == ftsm_pkg::DIV_DONE))
    else $error("divider did not finish after last step");

  // A result with no period reads as zero speed
  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !speed_valid) |-> (speed_rpm == '0))
    else $error("invalid speed result is not zero");

  // Loading the output register presents a result and frees the divider
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (result_valid && state == ftsm_pkg::DIV_IDLE))
    else $error("result load did not take effect");

  // Queue is popped only when the divider is free
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ftsm_pkg::DIV_IDLE && q_valid))
    else $error("queue popped while divider busy");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fan tachometer speed meter
// Drives tachometer samples with random bursts and gaps against a stalling
// result side. An in-bench model tracks edge times and periods, predicts
// each speed reading and compares it field by field with the block output.
// ----------------------------------------------------------------------------

module tb;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 313;
  localparam int DIR_ITEMS    = 25;
  localparam int HOLD_CYCLES  = 600;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;

  // rpm_scale lives at byte address 0
  localparam logic [ftsm_pkg::PADDR_W-1:0] ADDR_RPM_SCALE = {ftsm_pkg::REG_RPM_SCALE, 2'b00};

  // Directed levels: first rise, fall, wrapped rise, then glitches
  localparam bit [0:DIR_ITEMS-1] DIR_LEVELS = 25'b0111110000011111010000101;

  typedef struct {
    logic [ftsm_pkg::SPEED_W-1:0] rpm;
    logic                         ok;
  } speed_reading_t;

  // Edge tracker and divider model plus the queue of pending readings
  class rpm_checker;
    logic [ftsm_pkg::SCALE_W-1:0]     scale;
    logic [ftsm_pkg::HIST_W-1:0]      history;
    logic [ftsm_pkg::TSTAMP_IN_W-1:0] rise_at, rise_per, fall_at, fall_per;
    speed_reading_t                   expected_speeds[$];
    int                               errors;

    function new();
      scale    = ftsm_pkg::RPM_SCALE_RESET;
      history  = '0;
      rise_at  = '0;
      rise_per = '0;
      fall_at  = '0;
      fall_per = '0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_speeds.size();
    endfunction

    // One accepted sample: update edge state, queue the reading it yields
    function void tach_sample(logic lvl, logic [ftsm_pkg::TSTAMP_IN_W-1:0] ts);
      logic [ftsm_pkg::WIN_W-1:0]     win;
      logic [ftsm_pkg::TSTAMP_IN_W:0] half;
      logic [ftsm_pkg::SCALE_W-1:0]   quot;
      speed_reading_t                 want;
      win     = {history, lvl};
      history = win[ftsm_pkg::HIST_W-1:0];
      if (win == ftsm_pkg::WIN_RISE) begin
        rise_per = ts - rise_at;
        rise_at  = ts;
      end
      if (win == ftsm_pkg::WIN_FALL) begin
        fall_per = ts - fall_at;
        fall_at  = ts;
      end
      // exact floor of the half sum
      half    = ({1'b0, rise_per} + {1'b0, fall_per}) >> 1;
      want.ok = (half != '0);
      if (want.ok) begin
        quot     = scale / half[ftsm_pkg::TSTAMP_IN_W-1:0];
        want.rpm = (quot > ftsm_pkg::SPEED_MAX) ? ftsm_pkg::SPEED_MAX
                                                : quot[ftsm_pkg::SPEED_W-1:0];
      end else begin
        want.rpm = '0;
      end
      expected_speeds.push_back(want);
    endfunction

    // One accepted result against the oldest pending reading
    function void speed_result(logic [ftsm_pkg::SPEED_W-1:0] rpm, logic ok);
      speed_reading_t want;
      if (expected_speeds.size() == 0) begin
        $error("unexpected result: speed_rpm %0d speed_valid %0d", rpm, ok);
        errors++;
        return;
      end
      want = expected_speeds.pop_front();
      if (rpm !== want.rpm) begin
        $error("speed_rpm: expected %0d, got %0d", want.rpm, rpm);
        errors++;
      end
      if (ok !== want.ok) begin
        $error("speed_valid: expected %0d, got %0d", want.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             sample_valid;
  logic                             sample_stall;
  logic                             tach_level;
  logic [ftsm_pkg::TSTAMP_IN_W-1:0] timestamp;
  logic                             result_valid;
  logic                             result_stall;
  logic [ftsm_pkg::SPEED_W-1:0]     speed_rpm;
  logic                             speed_valid;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [ftsm_pkg::PADDR_W-1:0]     paddr;
  logic [ftsm_pkg::PDATA_W-1:0]     pwdata;
  logic [ftsm_pkg::PDATA_W-1:0]     prdata;
  logic                             pready;

  rpm_checker chk;
  bit         hold_req;
  int         burst_left;
  int         idle_count;

  fan_tacho_speed_meter u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .tach_level   (tach_level),
    .timestamp    (timestamp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .speed_rpm    (speed_rpm),
    .speed_valid  (speed_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: a transfer happens on a rising edge with valid high, stall low
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) chk.tach_sample(tach_level, timestamp);
      if (result_valid && !result_stall) chk.speed_result(speed_rpm, speed_valid);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count == IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side stall pattern, with a long hold-off on request
  initial begin
    int mode;
    int len;
    int k;
    result_stall = 1'b0;
    k = 0;
    forever begin
      if (hold_req) begin
        @(negedge clk) result_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(8, 80);
        repeat (len) begin
          @(negedge clk);
          k++;
          case (mode)
            0:       result_stall = 1'b0;
            1:       result_stall = ($urandom_range(0, 3) == 0);
            2:       result_stall = ($urandom_range(0, 3) != 0);
            default: result_stall = ((k % 5) < 2);
          endcase
        end
      end
    end
  end

  // Offer one sample, with random gaps between bursts
  task automatic send_sample(input logic lvl, input logic [ftsm_pkg::TSTAMP_IN_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk) sample_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    sample_valid = 1'b1;
    tach_level   = lvl;
    timestamp    = ts;
    do @(posedge clk); while (sample_stall);
  endtask

  // Stop offering and wait until every reading has come back
  task automatic wait_drained();
    @(negedge clk) sample_valid = 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_scale(input logic [ftsm_pkg::SCALE_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_RPM_SCALE;
    pwdata  = value;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    chk.scale = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Main sequence
  initial begin
    logic                             lvl;
    logic [ftsm_pkg::TSTAMP_IN_W-1:0] ts;
    logic [ftsm_pkg::SCALE_W-1:0]     scale_val;
    int unsigned                      inc_max;
    int                               run_left;

    chk          = new();
    hold_req     = 1'b0;
    burst_left   = 0;
    rst          = 1'b1;
    sample_valid = 1'b0;
    tach_level   = 1'b0;
    timestamp    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: no period yet, first rise at all-ones time,
    // wrapped rise period with saturation, then glitches
    for (int i = 0; i < DIR_ITEMS; i++) begin
      case (i)
        0:       ts = '0;
        3:       ts = '1;
        8:       ts = 32'd10;
        13:      ts = 32'd32;
        default: ts = i * 3;
      endcase
      send_sample(DIR_LEVELS[i], ts);
    end

    // Random square waves with noise, one scale setting per phase
    lvl      = 1'b0;
    run_left = 0;
    inc_max  = 1000;
    ts       = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       scale_val = 32'd1;
        1:       scale_val = '1;
        2:       scale_val = ftsm_pkg::RPM_SCALE_RESET;
        4:       scale_val = 32'd60000;
        default: scale_val = $urandom_range(32'hFFFF_FFFF, 1);
      endcase
      write_scale(scale_val);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          lvl = !lvl;
          // mostly qualified runs, some too short to qualify
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 10);
        end
        run_left--;
        if ($urandom_range(0, 15) == 0) inc_max = 1 << $urandom_range(1, 24);
        if ($urandom_range(0, 63) == 0) ts = $urandom;
        else ts = ts + $urandom_range(1, inc_max);
        // single-sample glitch now and then
        send_sample(($urandom_range(0, 15) == 0) ? !lvl : lvl, ts);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.pending() != 0) begin
      $error("%0d speed readings never arrived", chk.pending());
      chk.errors++;
    end
    if (chk.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
